FILE: src/three_anchor_trilateration_macros.svh
// Assertion macros for the three anchor trilateration block.
// Included by the top level; depends on nothing else.
`ifndef THREE_ANCHOR_TRILATERATION_MACROS_SVH
`define THREE_ANCHOR_TRILATERATION_MACROS_SVH

// same-cycle implication, disabled in reset
`define TAT_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("trilateration assertion failed");

// next-cycle implication, disabled in reset
`define TAT_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("trilateration assertion failed");

`endif

FILE: src/tat_pkg.sv
// Shared types, constants and the arctangent table of the trilateration block.
// No dependencies.
package tat_pkg;

   localparam int CORDIC_STAGES = 16;
   localparam int CORDIC_N      = (CORDIC_STAGES > 24) ? 24 : CORDIC_STAGES;

   localparam int NUM_W     = 101;  // Cramer numerator, signed
   localparam int DEN_W     = 68;   // |2*det|
   localparam int DIV_QBITS = 35;   // quotient bits; larger always saturates

   // pipeline stage numbers (valid bit index)
   localparam int STG_DIV0  = 8;
   localparam int STG_F1    = STG_DIV0 + DIV_QBITS;
   localparam int STG_F2    = STG_F1 + 1;
   localparam int STG_CPRE  = STG_F2 + 1;
   localparam int STG_COR0  = STG_CPRE + 1;
   localparam int PIPE_LAST = STG_COR0 + CORDIC_N - 1;

   localparam logic signed [17:0] PI_Q13 = 18'sd25736;

   typedef enum logic [2:0] {
      REG_ANCHOR_A_X = 3'd0,
      REG_ANCHOR_A_Y = 3'd1,
      REG_ANCHOR_B_X = 3'd2,
      REG_ANCHOR_B_Y = 3'd3,
      REG_ANCHOR_C_X = 3'd4,
      REG_ANCHOR_C_Y = 3'd5
   } csr_index_type;

   typedef struct packed {
      logic [DEN_W-1:0]     rem;
      logic [DIV_QBITS-1:0] low;
      logic [DIV_QBITS-1:0] quo;
      logic [DEN_W-1:0]     den;
      logic                 neg;
      logic                 ovf;
   } div_lane_type;

   typedef struct packed {
      logic signed [34:0] x;
      logic signed [34:0] y;
      logic signed [17:0] z;
      logic               zero;
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
   } cordic_lane_type;

   function automatic logic signed [17:0] atan_q13(input logic [4:0] idx);
      logic signed [17:0] a;
      case (idx)
         5'd0:    a = 18'sd6434;
         5'd1:    a = 18'sd3798;
         5'd2:    a = 18'sd2007;
         5'd3:    a = 18'sd1019;
         5'd4:    a = 18'sd511;
         5'd5:    a = 18'sd256;
         5'd6:    a = 18'sd128;
         5'd7:    a = 18'sd64;
         5'd8:    a = 18'sd32;
         5'd9:    a = 18'sd16;
         5'd10:   a = 18'sd8;
         5'd11:   a = 18'sd4;
         5'd12:   a = 18'sd2;
         5'd13:   a = 18'sd1;
         default: a = 18'sd0;
      endcase
      return a;
   endfunction

endpackage

FILE: src/three_anchor_trilateration.sv
// Top level of the three anchor trilateration block.
// Depends on tat_pkg, tat_div_cell, tat_cordic_cell and the macros header.
//
// Takes three ranges (Q16.16) to anchors A, B, C held in csr registers and
// returns the tag position by exact Cramer solution of the linearized 2x2
// system, floor-rounded and saturated to 32 bits, plus the heading atan2(y,x)
// in Q3.13 from a vectoring CORDIC. Zero determinant sets singular and zeroes
// every other field. Throughput is one request per cycle while the pipe does
// not stall. The capture register loads at the accepting edge. After it come
// seven multiply/add stages, the chain of 35 restoring-division cells (one
// quotient bit each), the floor and saturation stages, the pi pre-rotation,
// CORDIC_STAGES rotation cells and the output register.
// Anchors are read live by the pipe; write them only while it is empty.
// The whole pipe stalls only when its last stage holds a result and the
// output register is still waiting on rsp_tready.
`include "three_anchor_trilateration_macros.svh"

module three_anchor_trilateration import tat_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   // range_a [30:0], range_b [61:31], range_c [92:62], zero pad
   input  logic [95:0] req_tdata,
   input  logic        req_tvalid,
   output logic        req_tready,
   // pos_x [31:0], pos_y [63:32], heading [79:64]
   output logic [79:0] rsp_tdata,
   // singular [0]
   output logic        rsp_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_wdata
);

   localparam logic signed [37:0] SAT_HI = 38'sd2147483647;
   localparam logic signed [37:0] SAT_LO = -38'sd2147483648;

   // ---------------- anchor registers ----------------
   logic signed [31:0] ax_ff, ay_ff, bx_ff, by_ff, cx_ff, cy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         ax_ff <= '0; ay_ff <= '0; bx_ff <= '0;
         by_ff <= '0; cx_ff <= '0; cy_ff <= '0;
      end else if (csr_we) begin
         case (csr_index)
            REG_ANCHOR_A_X: ax_ff <= csr_wdata;
            REG_ANCHOR_A_Y: ay_ff <= csr_wdata;
            REG_ANCHOR_B_X: bx_ff <= csr_wdata;
            REG_ANCHOR_B_Y: by_ff <= csr_wdata;
            REG_ANCHOR_C_X: cx_ff <= csr_wdata;
            REG_ANCHOR_C_Y: cy_ff <= csr_wdata;
            default: ;  // unmapped index, write dropped
         endcase
      end
   end

   // anchor offsets from A
   logic signed [32:0] dbx, dby, dcx, dcy;
   assign dbx = 33'(bx_ff) - 33'(ax_ff);
   assign dby = 33'(by_ff) - 33'(ay_ff);
   assign dcx = 33'(cx_ff) - 33'(ax_ff);
   assign dcy = 33'(cy_ff) - 33'(ay_ff);

   // ---------------- flow control ----------------
   logic [PIPE_LAST:0] valid_ff;
   logic [PIPE_LAST:2] sing_ff;
   logic               rsp_tvalid_ff;
   logic               out_hold;
   logic               en;

   assign out_hold   = rsp_tvalid_ff && !rsp_tready;
   assign en         = !out_hold || !valid_ff[PIPE_LAST];
   assign req_tready = en;
   assign rsp_tvalid = rsp_tvalid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= {valid_ff[PIPE_LAST-1:0], req_tvalid};
      end
   end

   // ---------------- stage 0: capture ranges ----------------
   logic [30:0] ra_ff, rb_ff, rc_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         ra_ff <= req_tdata[30:0];
         rb_ff <= req_tdata[61:31];
         rc_ff <= req_tdata[92:62];
      end
   end

   // ---------------- stage 1: products ----------------
   logic signed [65:0] p_bxcy_ff, p_bycx_ff;
   logic signed [65:0] sq_bx_ff, sq_by_ff, sq_cx_ff, sq_cy_ff;
   logic        [61:0] ra2_ff, rb2_ff, rc2_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         p_bxcy_ff <= dbx * dcy;
         p_bycx_ff <= dby * dcx;
         sq_bx_ff  <= dbx * dbx;
         sq_by_ff  <= dby * dby;
         sq_cx_ff  <= dcx * dcx;
         sq_cy_ff  <= dcy * dcy;
         ra2_ff    <= 62'(ra_ff) * 62'(ra_ff);
         rb2_ff    <= 62'(rb_ff) * 62'(rb_ff);
         rc2_ff    <= 62'(rc_ff) * 62'(rc_ff);
      end
   end

   // ---------------- stage 2: determinant and right-hand sides ----------------
   logic signed [66:0] det_in, det2_ff, det3_ff, det4_ff, det5_ff;
   logic        [66:0] e1_in, e2_in, e1_ff, e2_ff;

   always_comb begin
      det_in = 67'(p_bxcy_ff) - 67'(p_bycx_ff);
      e1_in  = 67'(sq_bx_ff) + 67'(sq_by_ff) + 67'(ra2_ff) - 67'(rb2_ff);
      e2_in  = 67'(sq_cx_ff) + 67'(sq_cy_ff) + 67'(ra2_ff) - 67'(rc2_ff);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         det2_ff <= det_in;
         e1_ff   <= e1_in;
         e2_ff   <= e2_in;
         sing_ff <= {sing_ff[PIPE_LAST-1:2], (det_in == '0)};
      end
   end

   // ---------------- stage 3: split 67x33 products ----------------
   logic signed [67:0] m_e1lo_cy_ff, m_e2lo_by_ff, m_e2lo_bx_ff, m_e1lo_cx_ff;
   logic signed [65:0] m_e1hi_cy_ff, m_e2hi_by_ff, m_e2hi_bx_ff, m_e1hi_cx_ff;
   logic signed [34:0] e1_lo, e2_lo;
   logic signed [32:0] e1_hi, e2_hi;

   assign e1_lo = $signed({1'b0, e1_ff[33:0]});
   assign e2_lo = $signed({1'b0, e2_ff[33:0]});
   assign e1_hi = $signed(e1_ff[66:34]);
   assign e2_hi = $signed(e2_ff[66:34]);

   always_ff @(posedge clock) begin
      if (en) begin
         m_e1lo_cy_ff <= e1_lo * dcy;
         m_e1hi_cy_ff <= e1_hi * dcy;
         m_e2lo_by_ff <= e2_lo * dby;
         m_e2hi_by_ff <= e2_hi * dby;
         m_e2lo_bx_ff <= e2_lo * dbx;
         m_e2hi_bx_ff <= e2_hi * dbx;
         m_e1lo_cx_ff <= e1_lo * dcx;
         m_e1hi_cx_ff <= e1_hi * dcx;
         det3_ff      <= det2_ff;
      end
   end

   // ---------------- stage 4: recombine partial products ----------------
   logic signed [NUM_W-1:0] t_e1cy_ff, t_e2by_ff, t_e2bx_ff, t_e1cx_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         t_e1cy_ff <= NUM_W'($signed({m_e1hi_cy_ff, 34'b0})) + NUM_W'(m_e1lo_cy_ff);
         t_e2by_ff <= NUM_W'($signed({m_e2hi_by_ff, 34'b0})) + NUM_W'(m_e2lo_by_ff);
         t_e2bx_ff <= NUM_W'($signed({m_e2hi_bx_ff, 34'b0})) + NUM_W'(m_e2lo_bx_ff);
         t_e1cx_ff <= NUM_W'($signed({m_e1hi_cx_ff, 34'b0})) + NUM_W'(m_e1lo_cx_ff);
         det4_ff   <= det3_ff;
      end
   end

   // ---------------- stage 5: Cramer numerators ----------------
   logic signed [NUM_W-1:0] numx_ff, numy_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         numx_ff <= t_e1cy_ff - t_e2by_ff;
         numy_ff <= t_e2bx_ff - t_e1cx_ff;
         det5_ff <= det4_ff;
      end
   end

   // ---------------- stage 6: magnitudes and quotient signs ----------------
   logic [NUM_W-1:0] nabsx_ff, nabsy_ff;
   logic [DEN_W-1:0] den_ff;
   logic [66:0]      dabs;
   logic             negx_ff, negy_ff;

   assign dabs = det5_ff[66] ? 67'(-det5_ff) : 67'(det5_ff);

   always_ff @(posedge clock) begin
      if (en) begin
         nabsx_ff <= numx_ff[NUM_W-1] ? NUM_W'(-numx_ff) : NUM_W'(numx_ff);
         nabsy_ff <= numy_ff[NUM_W-1] ? NUM_W'(-numy_ff) : NUM_W'(numy_ff);
         den_ff   <= {dabs, 1'b0};
         negx_ff  <= numx_ff[NUM_W-1] ^ det5_ff[66];
         negy_ff  <= numy_ff[NUM_W-1] ^ det5_ff[66];
      end
   end

   // ---------------- stage 7: divider setup and overflow check ----------------
   div_lane_type init_x_in, init_y_in, init_x_ff, init_y_ff;

   always_comb begin
      init_x_in.rem = DEN_W'(nabsx_ff[NUM_W-1:DIV_QBITS]);
      init_x_in.low = nabsx_ff[DIV_QBITS-1:0];
      init_x_in.quo = '0;
      init_x_in.den = den_ff;
      init_x_in.neg = negx_ff;
      init_x_in.ovf = (DEN_W'(nabsx_ff[NUM_W-1:DIV_QBITS]) >= den_ff);
      init_y_in.rem = DEN_W'(nabsy_ff[NUM_W-1:DIV_QBITS]);
      init_y_in.low = nabsy_ff[DIV_QBITS-1:0];
      init_y_in.quo = '0;
      init_y_in.den = den_ff;
      init_y_in.neg = negy_ff;
      init_y_in.ovf = (DEN_W'(nabsy_ff[NUM_W-1:DIV_QBITS]) >= den_ff);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         init_x_ff <= init_x_in;
         init_y_ff <= init_y_in;
      end
   end

   // ---------------- division chains, one quotient bit per cell ----------------
   div_lane_type div_x [DIV_QBITS];
   div_lane_type div_y [DIV_QBITS];

   for (genvar k = 0; k < DIV_QBITS; k++) begin : g_div
      tat_div_cell u_div_x (
         .clock   (clock),
         .en      (en),
         .up_lane ((k == 0) ? init_x_ff : div_x[(k == 0) ? 0 : k-1]),
         .lane_ff (div_x[k])
      );
      tat_div_cell u_div_y (
         .clock   (clock),
         .en      (en),
         .up_lane ((k == 0) ? init_y_ff : div_y[(k == 0) ? 0 : k-1]),
         .lane_ff (div_y[k])
      );
   end

   // ---------------- F1: signed floor quotient ----------------
   div_lane_type       qx, qy;
   logic signed [35:0] svx_ff, svy_ff;
   logic               ovfx_ff, ovfy_ff, sgnx_ff, sgny_ff;

   assign qx = div_x[DIV_QBITS-1];
   assign qy = div_y[DIV_QBITS-1];

   // negative with remainder: -(q+1) == ~q
   always_ff @(posedge clock) begin
      if (en) begin
         svx_ff  <= qx.neg ? ({1'b1, ~qx.quo} + 36'(qx.rem == '0)) : {1'b0, qx.quo};
         svy_ff  <= qy.neg ? ({1'b1, ~qy.quo} + 36'(qy.rem == '0)) : {1'b0, qy.quo};
         ovfx_ff <= qx.ovf;
         ovfy_ff <= qy.ovf;
         sgnx_ff <= qx.neg;
         sgny_ff <= qy.neg;
      end
   end

   // ---------------- F2: add reference anchor, saturate ----------------
   logic signed [37:0] sumx, sumy;
   logic signed [31:0] px_in, py_in, px_ff, py_ff;

   always_comb begin
      sumx = 38'(ax_ff) + 38'(svx_ff);
      sumy = 38'(ay_ff) + 38'(svy_ff);
      if (ovfx_ff)            px_in = sgnx_ff ? 32'sh8000_0000 : 32'sh7fff_ffff;
      else if (sumx > SAT_HI) px_in = 32'sh7fff_ffff;
      else if (sumx < SAT_LO) px_in = 32'sh8000_0000;
      else                    px_in = sumx[31:0];
      if (ovfy_ff)            py_in = sgny_ff ? 32'sh8000_0000 : 32'sh7fff_ffff;
      else if (sumy > SAT_HI) py_in = 32'sh7fff_ffff;
      else if (sumy < SAT_LO) py_in = 32'sh8000_0000;
      else                    py_in = sumy[31:0];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         px_ff <= px_in;
         py_ff <= py_in;
      end
   end

   // ---------------- CORDIC pre-rotation by pi for x < 0 ----------------
   cordic_lane_type cpre_in, cpre_ff;

   always_comb begin
      cpre_in.pos_x = px_ff;
      cpre_in.pos_y = py_ff;
      cpre_in.zero  = (px_ff == '0) && (py_ff == '0);
      if (px_ff[31]) begin
         cpre_in.x = -35'(px_ff);
         cpre_in.y = -35'(py_ff);
         cpre_in.z = py_ff[31] ? -PI_Q13 : PI_Q13;
      end else begin
         cpre_in.x = 35'(px_ff);
         cpre_in.y = 35'(py_ff);
         cpre_in.z = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         cpre_ff <= cpre_in;
      end
   end

   // ---------------- CORDIC chain ----------------
   cordic_lane_type cor [CORDIC_N];

   for (genvar k = 0; k < CORDIC_N; k++) begin : g_cor
      tat_cordic_cell u_cor (
         .clock   (clock),
         .en      (en),
         .stage   (5'(k)),
         .up_lane ((k == 0) ? cpre_ff : cor[(k == 0) ? 0 : k-1]),
         .lane_ff (cor[k])
      );
   end

   // ---------------- output register ----------------
   cordic_lane_type    cl;
   logic signed [17:0] zc;
   logic signed [15:0] head_in;
   logic               sing_last;
   logic [79:0]        rsp_tdata_ff;
   logic               rsp_tuser_ff;

   assign cl        = cor[CORDIC_N-1];
   assign sing_last = sing_ff[PIPE_LAST];

   always_comb begin
      if (cl.z > PI_Q13)       zc = PI_Q13;
      else if (cl.z < -PI_Q13) zc = -PI_Q13;
      else                     zc = cl.z;
      head_in = (sing_last || cl.zero) ? 16'sd0 : zc[15:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else if (!out_hold) begin
         rsp_tvalid_ff <= valid_ff[PIPE_LAST];
      end
   end

   always_ff @(posedge clock) begin
      if (!out_hold) begin
         rsp_tdata_ff <= sing_last ? 80'd0 : {head_in, cl.pos_y, cl.pos_x};
         rsp_tuser_ff <= sing_last;
      end
   end

   assign rsp_tdata = rsp_tdata_ff;
   assign rsp_tuser = rsp_tuser_ff;

   // ---------------- assertions ----------------
   logic signed [15:0] rsp_head;
   assign rsp_head = rsp_tdata_ff[79:64];

   `TAT_ASSERT_NOW(a_sing_zero, clock, reset, rsp_tvalid_ff && rsp_tuser_ff, rsp_tdata_ff == '0)
   `TAT_ASSERT_NOW(a_head_range, clock, reset, rsp_tvalid_ff, (rsp_head <= 16'sd25736) && (rsp_head >= -16'sd25736))
   `TAT_ASSERT_NOW(a_bubble_ready, clock, reset, !valid_ff[PIPE_LAST], req_tready)
   `TAT_ASSERT_NEXT(a_stall_hold, clock, reset, !en, valid_ff[PIPE_LAST] && rsp_tvalid_ff)

endmodule

FILE: src/tat_div_cell.sv
// One restoring-division cell: takes one numerator bit, yields one quotient bit.
// Depends on tat_pkg.
module tat_div_cell import tat_pkg::*; (
   input  logic         clock,
   input  logic         en,
   input  div_lane_type up_lane,
   output div_lane_type lane_ff
);

   logic [DEN_W:0] trial;
   logic [DEN_W:0] diff;
   logic           take;
   div_lane_type   lane_in;

   always_comb begin
      trial   = {up_lane.rem, up_lane.low[DIV_QBITS-1]};
      diff    = trial - {1'b0, up_lane.den};
      take    = (trial >= {1'b0, up_lane.den});
      lane_in = up_lane;
      lane_in.rem = take ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      lane_in.low = {up_lane.low[DIV_QBITS-2:0], 1'b0};
      lane_in.quo = {up_lane.quo[DIV_QBITS-2:0], take};
   end

   always_ff @(posedge clock) begin
      if (en) begin
         lane_ff <= lane_in;
      end
   end

endmodule

FILE: src/tat_cordic_cell.sv
// One vectoring CORDIC rotation stage; stage number selects shift and angle.
// Depends on tat_pkg.
module tat_cordic_cell import tat_pkg::*; (
   input  logic            clock,
   input  logic            en,
   input  logic [4:0]      stage,
   input  cordic_lane_type up_lane,
   output cordic_lane_type lane_ff
);

   logic signed [34:0] xs;
   logic signed [34:0] ys;
   cordic_lane_type    lane_in;

   always_comb begin
      xs      = up_lane.x >>> stage;
      ys      = up_lane.y >>> stage;
      lane_in = up_lane;
      if (!up_lane.y[34]) begin
         lane_in.x = up_lane.x + ys;
         lane_in.y = up_lane.y - xs;
         lane_in.z = up_lane.z + atan_q13(stage);
      end else begin
         lane_in.x = up_lane.x - ys;
         lane_in.y = up_lane.y + xs;
         lane_in.z = up_lane.z - atan_q13(stage);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         lane_ff <= lane_in;
      end
   end

endmodule

FILE: dv/three_anchor_trilateration_tb.sv
// Self-checking testbench for three_anchor_trilateration.
// Depends on tat_pkg and the block's RTL; directed table then randomized ranges.
`timescale 1ns / 100ps

module three_anchor_trilateration_tb;
   import tat_pkg::*;

   localparam int          LATENCY = PIPE_LAST + 2;
   localparam longint      RMAX    = 64'h7FFF_FFFF;
   localparam logic [30:0] M10     = 31'd655360;   // 10 m in Q16.16

   typedef struct packed {
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [15:0] heading;
      logic               singular;
   } fix_type;

   // one directed row: cfg 0 = reset anchors, 1 = 10 m right triangle
   typedef struct {
      int          cfg;
      logic [30:0] ra, rb, rc;
      bit          typed;
      fix_type     fix;
   } row_type;

   logic        clock = 0;
   logic        reset = 1;
   logic [95:0] req_tdata = '0;
   logic        req_tvalid = 0;
   logic        req_tready;
   logic [79:0] rsp_tdata;
   logic        rsp_tuser;
   logic        rsp_tvalid;
   logic        rsp_tready = 0;
   logic        csr_we = 0;
   csr_index_type csr_index = REG_ANCHOR_A_X;
   logic [31:0] csr_wdata = '0;

   fix_type fix_q[$];
   row_type rows[$];
   longint  anchor_c[6];
   int      errors = 0;
   bit      calm = 0;          // no idling in the final stretch

   // arctangent table, Q3.13
   int atan_tab[24] = '{6434, 3798, 2007, 1019, 511, 256, 128, 64, 32, 16, 8, 4,
                        2, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0};

   three_anchor_trilateration u_top (
      .clock, .reset, .req_tdata, .req_tvalid, .req_tready,
      .rsp_tdata, .rsp_tuser, .rsp_tvalid, .rsp_tready,
      .csr_we, .csr_index, .csr_wdata
   );

   always begin
      #6 clock = 1;
      #6 clock = 0;
   end

   initial begin
      #5_000_000;
      $display("FAILED: results differ");
      $finish;
   end

   function automatic logic signed [31:0] sat32(logic signed [127:0] v);
      if (v > 128'sh7FFF_FFFF) return 32'sh7FFF_FFFF;
      if (v < -128'sh8000_0000) return 32'sh8000_0000;
      return v[31:0];
   endfunction

   // floor(num/den), magnitude clamped at 2^40 before the floor step
   function automatic logic signed [127:0] floor_quot(logic signed [127:0] num,
                                                      logic signed [127:0] den);
      logic signed [127:0] an, ad, q, r;
      bit neg;
      an  = num < 0 ? -num : num;
      ad  = den < 0 ? -den : den;
      neg = (num < 0) != (den < 0);
      q   = an / ad;
      r   = an % ad;
      if (q > (128'sd1 <<< 40)) q = 128'sd1 <<< 40;
      if (neg && r != 0) q = q + 1;
      return neg ? -q : q;
   endfunction

   function automatic logic signed [15:0] heading_of(longint y, longint x);
      longint z, xs, ys;
      z = 0;
      if (x == 0 && y == 0) return 0;
      if (x < 0) begin
         z = y >= 0 ? 25736 : -25736;
         x = -x;
         y = -y;
      end
      for (int i = 0; i < CORDIC_N; i++) begin
         xs = x >>> i;
         ys = y >>> i;
         if (y >= 0) begin
            x += ys; y -= xs; z += atan_tab[i];
         end else begin
            x -= ys; y += xs; z -= atan_tab[i];
         end
      end
      if (z > 25736) z = 25736;
      if (z < -25736) z = -25736;
      return z[15:0];
   endfunction

   function automatic fix_type solve_fix(logic [30:0] ra, logic [30:0] rb, logic [30:0] rc);
      logic signed [127:0] ax, ay, dbx, dby, dcx, dcy, det, e1, e2, ra2, den, px, py;
      fix_type f;
      ax  = anchor_c[0];
      ay  = anchor_c[1];
      dbx = anchor_c[2] - anchor_c[0];
      dby = anchor_c[3] - anchor_c[1];
      dcx = anchor_c[4] - anchor_c[0];
      dcy = anchor_c[5] - anchor_c[1];
      det = dbx * dcy - dby * dcx;
      f   = '0;
      if (det == 0) begin
         f.singular = 1;
         return f;
      end
      ra2 = {97'b0, ra} * {97'b0, ra};
      e1  = dbx * dbx + dby * dby + ra2 - {97'b0, rb} * {97'b0, rb};
      e2  = dcx * dcx + dcy * dcy + ra2 - {97'b0, rc} * {97'b0, rc};
      den = det + det;
      px  = sat32(ax + floor_quot(e1 * dcy - e2 * dby, den));
      py  = sat32(ay + floor_quot(e2 * dbx - e1 * dcx, den));
      f.pos_x   = px[31:0];
      f.pos_y   = py[31:0];
      f.heading = heading_of(longint'(f.pos_y), longint'(f.pos_x));
      return f;
   endfunction

   // append one row to the directed table
   function automatic void add_row(int cfg, logic [30:0] ra, logic [30:0] rb,
                                   logic [30:0] rc, bit typed, fix_type fix);
      row_type r;
      r.cfg   = cfg;
      r.ra    = ra;
      r.rb    = rb;
      r.rc    = rc;
      r.typed = typed;
      r.fix   = fix;
      rows.insert(rows.size(), r);
   endfunction

   // pipe must be empty; wait out the latency before touching anchors
   task automatic drain();
      wait (fix_q.size() == 0);
      repeat (LATENCY + 8) @(posedge clock);
   endtask

   task automatic load_anchors(longint v[6]);
      drain();
      for (int i = 0; i < 6; i++) begin
         csr_we    <= 1;
         csr_index <= csr_index_type'(i);
         csr_wdata <= v[i][31:0];
         anchor_c[i] = longint'($signed(v[i][31:0]));
         @(posedge clock);
      end
      csr_we <= 0;
      @(posedge clock);
   endtask

   // one request; prediction is queued at the accepting edge
   task automatic send(logic [30:0] ra, logic [30:0] rb, logic [30:0] rc, bit typed,
                       fix_type fix);
      req_tdata  <= {1'b0, rc, rb, ra};
      req_tvalid <= 1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      fix_q.insert(fix_q.size(), typed ? fix : solve_fix(ra, rb, rc));
      if (!calm && $urandom_range(0, 5) == 0) begin
         req_tvalid <= 0;
         repeat ($urandom_range(1, 18)) @(posedge clock);
      end
   endtask

   function automatic logic [30:0] rand_range(int mode);
      case (mode)
         0:       return 31'($urandom);
         1:       return 31'($urandom_range(0, 1 << 24));
         2:       return $urandom_range(0, 1) ? 31'h7FFF_FFFF : 31'h0;
         default: return 31'($urandom_range(0, 1 << 21));
      endcase
   endfunction

   function automatic longint rand_coord(int mode);
      case (mode)
         0:       return longint'($signed($urandom));
         1:       return longint'($signed($urandom_range(0, 1 << 27))) - (1 << 26);
         default: return $urandom_range(0, 1) ? RMAX : -RMAX - 1;
      endcase
   endfunction

   // result checker
   always @(posedge clock) begin
      fix_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = {rsp_tdata[31:0], rsp_tdata[63:32], rsp_tdata[79:64], rsp_tuser};
         if (fix_q.size() == 0) begin
            $display("%0t unexpected result: actual %h", $time, got);
            errors++;
         end else begin
            want = fix_q.pop_front();
            if (got.pos_x !== want.pos_x) begin
               $display("%0t pos_x: expected %h actual %h", $time, want.pos_x, got.pos_x);
               errors++;
            end
            if (got.pos_y !== want.pos_y) begin
               $display("%0t pos_y: expected %h actual %h", $time, want.pos_y, got.pos_y);
               errors++;
            end
            if (got.heading !== want.heading) begin
               $display("%0t heading: expected %h actual %h", $time, want.heading,
                        got.heading);
               errors++;
            end
            if (got.singular !== want.singular) begin
               $display("%0t singular: expected %b actual %b", $time, want.singular,
                        got.singular);
               errors++;
            end
         end
      end
   end

   // receiver stalls in bursts
   always @(posedge clock) begin
      int hold;
      if (reset || calm) begin
         rsp_tready <= !reset;
      end else if (hold > 0) begin
         hold--;
      end else if ($urandom_range(0, 4) == 0) begin
         rsp_tready <= ~rsp_tready;
         hold = $urandom_range(0, 17);
      end else begin
         rsp_tready <= 1;
      end
   end

   initial begin
      row_type r;
      fix_type nofix, sing;
      longint  tri_a[6], v[6];
      int      cur_cfg;

      nofix = '0;
      sing  = '0;
      sing.singular = 1;
      tri_a = '{0, 0, M10, 0, 0, M10};
      foreach (anchor_c[i]) anchor_c[i] = 0;

      // reset anchors are all zero: every request is singular
      add_row(0, 31'h0, 31'h0, 31'h0, 1, sing);
      add_row(0, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 1, sing);
      add_row(0, 31'h5555_5555, 31'h2AAA_AAAA, 31'h7FFF_FFFF, 1, sing);
      // tag at anchor A: origin, heading forced to zero
      add_row(1, 31'h0, M10, M10, 1, nofix);
      add_row(1, 31'd327680, 31'd536857, 31'd442037, 0, nofix);  // near (3,4) m
      add_row(1, 31'h7FFF_FFFF, 31'h0, 31'h0, 0, nofix);         // far out, saturates
      add_row(1, 31'h0, 31'h7FFF_FFFF, 31'h0, 0, nofix);
      add_row(1, 31'h0, 31'h0, 31'h7FFF_FFFF, 0, nofix);
      add_row(1, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 0, nofix);
      add_row(1, M10, 31'h0, M10 * 2, 0, nofix);                 // x positive, y negative
      add_row(1, M10 * 2, M10, 31'h0, 0, nofix);
      add_row(1, 31'h0000_0001, 31'h0, 31'h0, 0, nofix);
      add_row(1, 31'h2AAA_AAAA, 31'h5555_5555, 31'h1234_5678, 0, nofix);

      repeat (12) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      cur_cfg = 0;
      foreach (rows[i]) begin
         r = rows[i];
         if (r.cfg != cur_cfg) begin
            req_tvalid <= 0;
            load_anchors(tri_a);
            cur_cfg = r.cfg;
         end
         send(r.ra, r.rb, r.rc, r.typed, r.fix);
      end

      // phases: extremes, collinear (singular), tiny regular, then random extreme, small and full-range anchors
      for (int ph = 0; ph < 12; ph++) begin
         req_tvalid <= 0;
         case (ph)
            0: v = '{-RMAX - 1, -RMAX - 1, RMAX, -RMAX - 1, -RMAX - 1, RMAX};
            1: v = '{RMAX, RMAX, -RMAX - 1, RMAX, RMAX, -RMAX - 1};
            2: begin
               v[0] = rand_coord(1); v[1] = rand_coord(1);
               v[2] = v[0] + 1000;   v[3] = v[1] + 2000;
               v[4] = v[0] - 3000;   v[5] = v[1] - 6000;     // on one line
            end
            3: v = '{0, 0, 1, 0, 0, 1};                      // tiny but regular
            default: foreach (v[k]) v[k] = rand_coord(ph % 3 == 0 ? 2 : ph % 2);
         endcase
         calm = (ph == 11);
         load_anchors(v);
         for (int n = 0; n < 125; n++)
            send(rand_range($urandom_range(0, 3)), rand_range($urandom_range(0, 3)),
                 rand_range($urandom_range(0, 3)), 0, nofix);
      end
      req_tvalid <= 0;

      wait (fix_q.size() == 0);
      repeat (LATENCY + 20) @(posedge clock);
      if (errors == 0 && fix_q.size() == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

endmodule

FILE: sim.f
+incdir+src
src/tat_pkg.sv
src/tat_div_cell.sv
src/tat_cordic_cell.sv
src/three_anchor_trilateration.sv
dv/three_anchor_trilateration_tb.sv
